// ----- hdl/assert_macros.svh -----
// Assertion macros used by the top-level RTL file of the LED strip frame buffer.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: implication check failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

// The expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("%m: invariant check failed");

`endif

// ----- hdl/lsrfb_pkg.sv -----
// Package of the LED strip ring frame buffer: sizes, command, status and step
// codes, the step unit and store port types and address helpers. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package lsrfb_pkg;

    // Strip geometry.
    localparam int LEDS_PER_STRIP = 32;
    localparam int STRIP_COUNT    = 4;
    localparam int DEPTH          = LEDS_PER_STRIP * STRIP_COUNT;

    localparam int FRONT_W = (LEDS_PER_STRIP > 1) ? $clog2(LEDS_PER_STRIP) : 1;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FSEL_W  = (STRIP_COUNT > 1) ? $clog2(STRIP_COUNT) : 1;

    localparam logic [FRONT_W-1:0] LAST_LED = FRONT_W'(LEDS_PER_STRIP - 1);

    // Command codes.
    localparam logic [1:0] ACT_PUSH  = 2'd0;
    localparam logic [1:0] ACT_SET   = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;
    localparam logic [1:0] ACT_SHOW  = 2'd3;

    // Status codes.
    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_RANGE = 1'b1;

    // Step unit operations.
    localparam logic STEP_INC = 1'b0;
    localparam logic STEP_DEC = 1'b1;

    typedef struct packed {
        logic               op;
        logic [FRONT_W-1:0] value;
    } step_req_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [23:0]       data;
    } mem_wr_t;

    typedef struct packed {
        logic              re;
        logic [ADDR_W-1:0] addr;
    } mem_rd_t;

    // A strip number names a real strip.
    function automatic logic strip_ok(input logic [1:0] strip);
        return int'(strip) < STRIP_COUNT;
    endfunction

    // Flat store address of one LED of one strip.
    function automatic logic [ADDR_W-1:0] led_addr(input logic [1:0] strip,
                                                   input logic [FRONT_W-1:0] idx);
        return ADDR_W'(int'(strip) * LEDS_PER_STRIP + int'(idx));
    endfunction

endpackage

`default_nettype wire

// ----- hdl/lsrfb_if.sv -----
// Channel interfaces of the LED strip ring frame buffer: the command
// channel and the result channel. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface lsrfb_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [1:0] strip;
    logic [6:0] position;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;

    modport source (output valid, action, strip, position, red_in, green_in, blue_in,
                    input ready);
    modport sink (input valid, action, strip, position, red_in, green_in, blue_in,
                  output ready);
endinterface

interface lsrfb_res_if;
    logic       valid;
    logic       ready;
    logic       is_pixel;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [1:0] mux_select;
    logic       last;
    logic       status;

    modport source (output valid, is_pixel, red_out, green_out, blue_out, mux_select,
                    last, status, input ready);
    modport sink (input valid, is_pixel, red_out, green_out, blue_out, mux_select,
                  last, status, output ready);
endinterface

`default_nettype wire

// ----- hdl/lsrfb_step_unit.sv -----
// Shared index step unit: increments or decrements an LED index with wrap
// around the strip length. Depends on lsrfb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lsrfb_step_unit (
    input  lsrfb_pkg::step_req_t            req,
    output logic [lsrfb_pkg::FRONT_W-1:0]   result
);

    // Wrap at the top for increments and at zero for decrements.
    always_comb
    begin
        unique case (req.op)
            lsrfb_pkg::STEP_INC:
            begin
                if (req.value == lsrfb_pkg::LAST_LED)
                    result = '0;
                else
                    result = req.value + 1'b1;
            end
            lsrfb_pkg::STEP_DEC:
            begin
                if (req.value == '0)
                    result = lsrfb_pkg::LAST_LED;
                else
                    result = req.value - 1'b1;
            end
            default:
                result = '0;
        endcase
    end

endmodule

`default_nettype wire

// ----- hdl/lsrfb_pixel_mem.sv -----
// Pixel store of all strips with one write and one registered read port.
// Per-entry valid bits make unwritten LEDs read dark after reset.
// Depends on lsrfb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lsrfb_pixel_mem (
    input  logic                clk,
    input  logic                rst_n,
    input  lsrfb_pkg::mem_wr_t  wr,
    input  lsrfb_pkg::mem_rd_t  rd,
    output logic [23:0]         rdata
);

    logic [23:0] mem [lsrfb_pkg::DEPTH];
    logic [lsrfb_pkg::DEPTH-1:0] valid_reg;
    logic [23:0] rd_reg;
    logic        rd_valid_reg;

    // Storage array and its registered read.
    always_ff @(posedge clk)
    begin
        if (wr.we)
            mem[wr.addr] <= wr.data;
        if (rd.re)
            rd_reg <= mem[rd.addr];
    end

    // Valid bits, cleared at once by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr.we)
                valid_reg[wr.addr] <= 1'b1;
            if (rd.re)
                rd_valid_reg <= valid_reg[rd.addr];
        end
    end

    // An entry never written reads as dark.
    assign rdata = rd_valid_reg ? rd_reg : 24'd0;

endmodule

`default_nettype wire

// ----- hdl/led_strip_ring_frame_buffer_unit.sv -----
// Top level of the LED strip ring frame buffer: command sequencer, front
// pointers and result register. Depends on lsrfb_pkg, lsrfb_if,
// lsrfb_step_unit, lsrfb_pixel_mem and assert_macros.svh.
//
//   channel  role    handshake      payload
//   cmd      sink    valid/ready    action, strip, position, red/green/blue_in
//   result   source  valid/ready    is_pixel, colours, mux_select, last, status
//
// Push and set pass through the write state to the acknowledge on result.
// Clear is a zeroing sweep that writes one LED a cycle, then acknowledges.
// Show streams the strip through the store's single read port, one LED a cycle
// while result is ready. A stalled result stalls the sweep.
// Reset clears the valid bits of the store at once; there is no clearing pass.
// cmd is ready only while the sequencer is idle.
`timescale 1ns / 1ps
`default_nettype none

module led_strip_ring_frame_buffer_unit (
    input  logic               clk,
    input  logic               rst_n,
    lsrfb_cmd_if.sink          cmd,
    lsrfb_res_if.source        result
);

    `include "assert_macros.svh"

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_WRITE   = 3'd1;
    localparam logic [2:0] ST_CLEAR   = 3'd2;
    localparam logic [2:0] ST_SHOW_RD = 3'd3;
    localparam logic [2:0] ST_SHOW    = 3'd4;
    localparam logic [2:0] ST_ACK     = 3'd5;

    localparam int FW = lsrfb_pkg::FRONT_W;

    logic [2:0]    state_reg, state_next;
    logic [1:0]    action_reg, action_next;
    logic [1:0]    strip_reg, strip_next;
    logic [6:0]    pos_reg, pos_next;
    logic [23:0]   rgb_reg, rgb_next;
    logic          status_reg, status_next;
    logic [FW-1:0] cnt_reg, cnt_next;
    logic [FW-1:0] idx_reg, idx_next;
    logic [FW-1:0] front_reg [lsrfb_pkg::STRIP_COUNT];

    logic          front_we;
    logic [FW-1:0] front_wdata;
    logic [FW-1:0] front_cur;
    logic [lsrfb_pkg::FSEL_W-1:0] sel;

    logic          out_valid_reg;
    logic          out_pix_reg;
    logic [23:0]   out_rgb_reg;
    logic [1:0]    out_mux_reg;
    logic          out_last_reg;
    logic          out_status_reg;
    logic          out_free;
    logic          out_load;
    logic          load_pix;
    logic [23:0]   load_rgb;
    logic          load_last;
    logic          load_status;

    lsrfb_pkg::step_req_t step_req;
    logic [FW-1:0]        step_out;
    lsrfb_pkg::mem_wr_t   mem_wr;
    lsrfb_pkg::mem_rd_t   mem_rd;
    logic [23:0]          mem_rdata;

    lsrfb_step_unit u_step (
        .req    (step_req),
        .result (step_out)
    );

    lsrfb_pixel_mem u_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (mem_wr),
        .rd    (mem_rd),
        .rdata (mem_rdata)
    );

    assign sel       = strip_reg[lsrfb_pkg::FSEL_W-1:0];
    assign front_cur = front_reg[sel];
    assign out_free  = !out_valid_reg || result.ready;
    assign cmd.ready = (state_reg == ST_IDLE);

    // Operand of the shared step unit for each sequencer state.
    always_comb
    begin
        step_req.op    = lsrfb_pkg::STEP_INC;
        step_req.value = front_cur;
        unique case (state_reg)
            ST_WRITE:
                step_req.op = lsrfb_pkg::STEP_DEC;
            ST_CLEAR:
                step_req.value = cnt_reg;
            ST_SHOW:
                step_req.value = idx_reg;
            default:
                step_req.value = front_cur;
        endcase
    end

    // Command sequencer.
    always_comb
    begin
        state_next  = state_reg;
        action_next = action_reg;
        strip_next  = strip_reg;
        pos_next    = pos_reg;
        rgb_next    = rgb_reg;
        status_next = status_reg;
        cnt_next    = cnt_reg;
        idx_next    = idx_reg;
        front_we    = 1'b0;
        front_wdata = step_out;
        mem_wr      = '0;
        mem_rd      = '0;
        out_load    = 1'b0;
        load_pix    = 1'b0;
        load_rgb    = 24'd0;
        load_last   = 1'b1;
        load_status = status_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    action_next = cmd.action;
                    strip_next  = cmd.strip;
                    pos_next    = cmd.position;
                    rgb_next    = {cmd.red_in, cmd.green_in, cmd.blue_in};
                    status_next = lsrfb_pkg::STATUS_OK;
                    cnt_next    = '0;
                    if (!lsrfb_pkg::strip_ok(cmd.strip))
                        state_next = ST_ACK;
                    else
                    begin
                        unique case (cmd.action)
                            lsrfb_pkg::ACT_PUSH,
                            lsrfb_pkg::ACT_SET:   state_next = ST_WRITE;
                            lsrfb_pkg::ACT_CLEAR: state_next = ST_CLEAR;
                            lsrfb_pkg::ACT_SHOW:  state_next = ST_SHOW_RD;
                            default:              state_next = ST_ACK;
                        endcase
                    end
                end
            end

            ST_WRITE:
            begin
                state_next = ST_ACK;
                if (action_reg == lsrfb_pkg::ACT_PUSH)
                begin
                    mem_wr.we   = 1'b1;
                    mem_wr.addr = lsrfb_pkg::led_addr(strip_reg, front_cur);
                    mem_wr.data = rgb_reg;
                    front_we    = 1'b1;
                end
                else if (int'(pos_reg) < lsrfb_pkg::LEDS_PER_STRIP)
                begin
                    mem_wr.we   = 1'b1;
                    mem_wr.addr = lsrfb_pkg::led_addr(strip_reg, pos_reg[FW-1:0]);
                    mem_wr.data = rgb_reg;
                end
                else
                    status_next = lsrfb_pkg::STATUS_RANGE;
            end

            ST_CLEAR:
            begin
                mem_wr.we   = 1'b1;
                mem_wr.addr = lsrfb_pkg::led_addr(strip_reg, cnt_reg);
                mem_wr.data = 24'd0;
                if (cnt_reg == lsrfb_pkg::LAST_LED)
                begin
                    front_we    = 1'b1;
                    front_wdata = lsrfb_pkg::LAST_LED;
                    state_next  = ST_ACK;
                end
                else
                    cnt_next = step_out;
            end

            ST_SHOW_RD:
            begin
                mem_rd.re   = 1'b1;
                mem_rd.addr = lsrfb_pkg::led_addr(strip_reg, step_out);
                idx_next    = step_out;
                cnt_next    = '0;
                state_next  = ST_SHOW;
            end

            ST_SHOW:
            begin
                if (out_free)
                begin
                    out_load    = 1'b1;
                    load_pix    = 1'b1;
                    load_rgb    = mem_rdata;
                    load_status = lsrfb_pkg::STATUS_OK;
                    load_last   = (cnt_reg == lsrfb_pkg::LAST_LED);
                    if (cnt_reg == lsrfb_pkg::LAST_LED)
                        state_next = ST_IDLE;
                    else
                    begin
                        mem_rd.re   = 1'b1;
                        mem_rd.addr = lsrfb_pkg::led_addr(strip_reg, step_out);
                        idx_next    = step_out;
                        cnt_next    = cnt_reg + 1'b1;
                    end
                end
            end

            ST_ACK:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
                state_next = ST_IDLE;
        endcase
    end

    // Sequencer and front pointer registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            for (int s = 0; s < lsrfb_pkg::STRIP_COUNT; s++)
                front_reg[s] <= lsrfb_pkg::LAST_LED;
        end
        else
        begin
            state_reg <= state_next;
            if (front_we)
                front_reg[sel] <= front_wdata;
        end
    end

    // Latched command fields and walk counters.
    always_ff @(posedge clk)
    begin
        action_reg <= action_next;
        strip_reg  <= strip_next;
        pos_reg    <= pos_next;
        rgb_reg    <= rgb_next;
        status_reg <= status_next;
        cnt_reg    <= cnt_next;
        idx_reg    <= idx_next;
    end

    // Result register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_pix_reg    <= load_pix;
            out_rgb_reg    <= load_rgb;
            out_mux_reg    <= strip_reg;
            out_last_reg   <= load_last;
            out_status_reg <= load_status;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.is_pixel   = out_pix_reg;
    assign result.red_out    = out_rgb_reg[23:16];
    assign result.green_out  = out_rgb_reg[15:8];
    assign result.blue_out   = out_rgb_reg[7:0];
    assign result.mux_select = out_mux_reg;
    assign result.last       = out_last_reg;
    assign result.status     = out_status_reg;

    // A stalled result stays offered with its payload unchanged.
    `ASSERT_NEXT(a_hold_stalled, result.valid && !result.ready,
                 result.valid && $stable({result.is_pixel, result.red_out, result.green_out,
                                          result.blue_out, result.mux_select, result.last,
                                          result.status}))
    // An acknowledge is always dark.
    `ASSERT_IMPLY(a_ack_dark, result.valid && !result.is_pixel,
                  result.red_out == 8'd0 && result.green_out == 8'd0 && result.blue_out == 8'd0)
    // Streamed pixels never carry an error status.
    `ASSERT_IMPLY(a_pixel_ok, result.valid && result.is_pixel,
                  result.status == lsrfb_pkg::STATUS_OK)
    // The front pointer of the first strip stays inside the strip.
    `ASSERT_ALWAYS(a_front_range, int'(front_reg[0]) < lsrfb_pkg::LEDS_PER_STRIP)

endmodule

`default_nettype wire

// ----- sim/tb_led_strip_ring_frame_buffer_unit.sv -----
`timescale 1ns / 1ps
// Testbench of led_strip_ring_frame_buffer_unit: sends push, set, clear and show
// commands and checks every result against a frame store predictor.
// Depends on lsrfb_pkg, lsrfb_if and the RTL of the block.

typedef struct packed {
    logic       is_pixel;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [1:0] mux_select;
    logic       last;
    logic       status;
} led_reply_t;

// Keeps its own copy of the frame stores and front pointers, and the replies
// that accepted commands are still owed, oldest first.
class frame_scoreboard;
    localparam int FW = lsrfb_pkg::FRONT_W;

    logic [23:0]        frame [lsrfb_pkg::DEPTH];
    logic [FW-1:0]      front [lsrfb_pkg::STRIP_COUNT];
    led_reply_t         pending_replies [$];
    int                 mismatch_count;

    function new();
        mismatch_count = 0;
        for (int s = 0; s < lsrfb_pkg::STRIP_COUNT; s++)
        begin
            darken_strip(s);
        end
    endfunction

    function void darken_strip(int s);
        for (int i = 0; i < lsrfb_pkg::LEDS_PER_STRIP; i++)
        begin
            frame[s * lsrfb_pkg::LEDS_PER_STRIP + i] = 24'd0;
        end
        front[s] = lsrfb_pkg::LAST_LED;
    endfunction

    function void queue_ack(logic [1:0] strip, logic status);
        led_reply_t reply;
        reply            = '0;
        reply.mux_select = strip;
        reply.last       = 1'b1;
        reply.status     = status;
        pending_replies.push_back(reply);
    endfunction

    function int outstanding();
        return pending_replies.size();
    endfunction

    // Applies one accepted command to the predicted state and queues its replies.
    function void note_command(logic [1:0] action, logic [1:0] strip,
                               logic [6:0] position, logic [23:0] color);
        int         base;
        int         idx;
        led_reply_t reply;
        base = int'(strip) * lsrfb_pkg::LEDS_PER_STRIP;
        // A strip number past the last strip only earns an acknowledge.
        if (int'(strip) >= lsrfb_pkg::STRIP_COUNT)
        begin
            queue_ack(strip, lsrfb_pkg::STATUS_OK);
            return;
        end
        case (action)
            lsrfb_pkg::ACT_PUSH:
            begin
                idx = int'(front[strip]);
                if (idx >= lsrfb_pkg::LEDS_PER_STRIP)
                begin
                    idx = lsrfb_pkg::LEDS_PER_STRIP - 1;
                end
                frame[base + idx] = color;
                // The front moves down and wraps from zero to the top LED.
                front[strip] = (idx == 0) ? lsrfb_pkg::LAST_LED : FW'(idx - 1);
                queue_ack(strip, lsrfb_pkg::STATUS_OK);
            end
            lsrfb_pkg::ACT_SET:
            begin
                if (int'(position) >= lsrfb_pkg::LEDS_PER_STRIP)
                begin
                    queue_ack(strip, lsrfb_pkg::STATUS_RANGE);
                end
                else
                begin
                    frame[base + int'(position)] = color;
                    queue_ack(strip, lsrfb_pkg::STATUS_OK);
                end
            end
            lsrfb_pkg::ACT_CLEAR:
            begin
                darken_strip(int'(strip));
                queue_ack(strip, lsrfb_pkg::STATUS_OK);
            end
            default:
            begin
                // Show walks the ring from the LED after the front, wrapping.
                idx = int'(front[strip]);
                for (int c = 0; c < lsrfb_pkg::LEDS_PER_STRIP; c++)
                begin
                    idx = (idx + 1 >= lsrfb_pkg::LEDS_PER_STRIP) ? 0 : idx + 1;
                    reply.is_pixel   = 1'b1;
                    reply.red        = frame[base + idx][23:16];
                    reply.green      = frame[base + idx][15:8];
                    reply.blue       = frame[base + idx][7:0];
                    reply.mux_select = strip;
                    reply.last       = (c == lsrfb_pkg::LEDS_PER_STRIP - 1);
                    reply.status     = lsrfb_pkg::STATUS_OK;
                    pending_replies.push_back(reply);
                end
            end
        endcase
    endfunction

    function string show_reply(led_reply_t r);
        return $sformatf("pix=%0d rgb=%02h%02h%02h mux=%0d last=%0d status=%0d",
                         r.is_pixel, r.red, r.green, r.blue, r.mux_select, r.last,
                         r.status);
    endfunction

    // Compares one accepted result with the oldest pending reply.
    function void check_result(led_reply_t got);
        led_reply_t want;
        string      diffs;
        if (pending_replies.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
            begin
                $display("%0t: result with nothing pending: %s", $time, show_reply(got));
            end
            return;
        end
        want  = pending_replies.pop_front();
        diffs = "";
        if (got.is_pixel !== want.is_pixel)
            diffs = {diffs, " is_pixel"};
        if (got.red !== want.red)
            diffs = {diffs, " red"};
        if (got.green !== want.green)
            diffs = {diffs, " green"};
        if (got.blue !== want.blue)
            diffs = {diffs, " blue"};
        if (got.mux_select !== want.mux_select)
            diffs = {diffs, " mux_select"};
        if (got.last !== want.last)
            diffs = {diffs, " last"};
        if (got.status !== want.status)
            diffs = {diffs, " status"};
        if (diffs != "")
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
            begin
                $display("%0t: mismatch in%s: expected %s, got %s", $time, diffs,
                         show_reply(want), show_reply(got));
            end
        end
    endfunction
endclass

module tb_led_strip_ring_frame_buffer_unit;

    // Slowest run: about 520 commands, bursts closed by a show of 32 results,
    // each result waiting on a receiver that idles most of the time.
    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int ITEMS_PER_PHASE = 165;

    logic            clk;
    logic            rst_n;
    int              cycle_count = 0;
    int              send_idle_pct;
    int              recv_idle_pct;
    int              items_sent;
    frame_scoreboard scoreboard;

    lsrfb_cmd_if cmd_ch ();
    lsrfb_res_if res_ch ();

    led_strip_ring_frame_buffer_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd_ch),
        .result (res_ch)
    );

    initial clk = 1'b0;

    always #5 clk = ~clk;

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL led_strip_ring_frame_buffer_unit");
            $finish;
        end
    end

    // The receiver stalls at random; its ready changes only at the falling edge.
    always @(negedge clk)
    begin
        res_ch.ready = ($urandom_range(99) >= recv_idle_pct);
    end

    // Every result transaction goes to the scoreboard.
    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            scoreboard.check_result({res_ch.is_pixel, res_ch.red_out, res_ch.green_out,
                                     res_ch.blue_out, res_ch.mux_select, res_ch.last,
                                     res_ch.status});
        end
    end

    // Offers one command, after a random gap, and holds it until it is accepted.
    task automatic send_command(input logic [1:0] action, input logic [1:0] strip,
                                input logic [6:0] position, input logic [23:0] color);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_ch.valid = 1'b0;
            @(negedge clk);
        end
        cmd_ch.valid    = 1'b1;
        cmd_ch.action   = action;
        cmd_ch.strip    = strip;
        cmd_ch.position = position;
        cmd_ch.red_in   = color[23:16];
        cmd_ch.green_in = color[15:8];
        cmd_ch.blue_in  = color[7:0];
        @(posedge clk);
        while (!cmd_ch.ready)
        begin
            @(posedge clk);
        end
        scoreboard.note_command(action, strip, position, color);
        items_sent++;
    endtask

    // Holds commands back until every pending reply has come.
    task automatic drain_results();
        @(negedge clk);
        cmd_ch.valid = 1'b0;
        while (scoreboard.outstanding() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Mostly runs of pushes and sets on one strip closed by a show, so that the
    // fronts wrap; the rest is clears and commands of any kind.
    task automatic run_random_phase(input int quota);
        int         stop_at;
        int         roll;
        int         burst;
        logic [1:0] strip;
        logic [6:0] pos;
        stop_at = items_sent + quota;
        while (items_sent < stop_at)
        begin
            roll  = $urandom_range(99);
            strip = 2'($urandom_range(3));
            if (roll < 70)
            begin
                burst = $urandom_range(48, 1);
                if (burst > stop_at - items_sent)
                begin
                    burst = stop_at - items_sent;
                end
                repeat (burst)
                begin
                    if ($urandom_range(99) < 20)
                    begin
                        pos = ($urandom_range(99) < 75) ?
                              7'($urandom_range(lsrfb_pkg::LEDS_PER_STRIP - 1)) :
                              7'($urandom_range(127, lsrfb_pkg::LEDS_PER_STRIP));
                        send_command(lsrfb_pkg::ACT_SET, strip, pos, 24'($urandom));
                    end
                    else
                    begin
                        send_command(lsrfb_pkg::ACT_PUSH, strip, 7'($urandom),
                                     24'($urandom));
                    end
                end
                send_command(lsrfb_pkg::ACT_SHOW, strip, 7'($urandom), 24'($urandom));
            end
            else if (roll < 80)
            begin
                send_command(lsrfb_pkg::ACT_CLEAR, strip, 7'($urandom), 24'($urandom));
            end
            else
            begin
                send_command(2'($urandom_range(3)), strip, 7'($urandom), 24'($urandom));
            end
        end
    endtask

    initial
    begin
        rst_n           = 1'b0;
        cmd_ch.valid    = 1'b0;
        cmd_ch.action   = lsrfb_pkg::ACT_PUSH;
        cmd_ch.strip    = 2'd0;
        cmd_ch.position = 7'd0;
        cmd_ch.red_in   = 8'd0;
        cmd_ch.green_in = 8'd0;
        cmd_ch.blue_in  = 8'd0;
        res_ch.ready    = 1'b0;
        send_idle_pct   = 16;
        recv_idle_pct   = 74;
        items_sent      = 0;
        scoreboard      = new();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: a dark strip after reset, color extremes, set positions at
        // and past the strip length, the last strip, and clear then show.
        send_command(lsrfb_pkg::ACT_SHOW, 2'd0, 7'd0, 24'h000000);
        send_command(lsrfb_pkg::ACT_PUSH, 2'd0, 7'd0, 24'hFFFFFF);
        send_command(lsrfb_pkg::ACT_PUSH, 2'd0, 7'd0, 24'h000000);
        send_command(lsrfb_pkg::ACT_PUSH, 2'd0, 7'd127, 24'hA55AC3);
        send_command(lsrfb_pkg::ACT_SHOW, 2'd0, 7'd127, 24'hFFFFFF);
        send_command(lsrfb_pkg::ACT_SET, 2'd1, 7'd0, 24'h123456);
        send_command(lsrfb_pkg::ACT_SET, 2'd1, 7'(lsrfb_pkg::LEDS_PER_STRIP - 1),
                     24'hFFFFFF);
        send_command(lsrfb_pkg::ACT_SET, 2'd1, 7'(lsrfb_pkg::LEDS_PER_STRIP), 24'hFFFFFF);
        send_command(lsrfb_pkg::ACT_SET, 2'd1, 7'd127, 24'hFFFFFF);
        send_command(lsrfb_pkg::ACT_SET, 2'd1, 7'd85, 24'h5A5A5A);
        send_command(lsrfb_pkg::ACT_SHOW, 2'd1, 7'd0, 24'h000000);
        send_command(lsrfb_pkg::ACT_PUSH, 2'd3, 7'd42, 24'h5A5A5A);
        send_command(lsrfb_pkg::ACT_SET, 2'd3, 7'd16, 24'hABCDEF);
        send_command(lsrfb_pkg::ACT_SHOW, 2'd3, 7'd0, 24'h000000);
        send_command(lsrfb_pkg::ACT_CLEAR, 2'd0, 7'd127, 24'hFFFFFF);
        send_command(lsrfb_pkg::ACT_SHOW, 2'd0, 7'd0, 24'h000000);
        send_command(lsrfb_pkg::ACT_CLEAR, 2'd2, 7'd0, 24'h000000);
        send_command(lsrfb_pkg::ACT_SHOW, 2'd2, 7'd0, 24'h000000);
        send_command(lsrfb_pkg::ACT_PUSH, 2'd2, 7'd0, 24'h010203);
        send_command(lsrfb_pkg::ACT_SHOW, 2'd2, 7'd0, 24'h000000);

        run_random_phase(ITEMS_PER_PHASE);
        drain_results();

        send_idle_pct = 74;
        recv_idle_pct = 16;
        run_random_phase(ITEMS_PER_PHASE);
        drain_results();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random_phase(ITEMS_PER_PHASE);
        drain_results();

        // Give a stray result time to show up.
        repeat (lsrfb_pkg::LEDS_PER_STRIP + 8) @(posedge clk);
        if (scoreboard.mismatch_count == 0 && scoreboard.outstanding() == 0)
            $display("PASS led_strip_ring_frame_buffer_unit");
        else
            $display("FAIL led_strip_ring_frame_buffer_unit");
        $finish;
    end

endmodule
